### src/strided_index_to_address_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strided index to address block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STRIDED_INDEX_TO_ADDRESS_DEFINES_SVH
`define STRIDED_INDEX_TO_ADDRESS_DEFINES_SVH

// same-cycle implication
`define SITA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SITA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sita_pkg.sv
// ----------------------------------------------------------------------------
// sita_pkg
// Shared widths, register indexes and the pipeline item record.
// ----------------------------------------------------------------------------
`default_nettype none

package sita_pkg;

    localparam int IDX_W   = 32;
    localparam int ADDR_W  = 48;
    localparam int EXT_W   = 16;
    localparam int STR_W   = 16;
    localparam int SIZE_W  = 4;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 48;

    localparam logic [CIDX_W-1:0] CFG_BASE_ADDRESS  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_ITEM_SIZE     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_EXTENT_OUTER  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_EXTENT_MIDDLE = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_EXTENT_INNER  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_STRIDE_OUTER  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_STRIDE_MIDDLE = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_STRIDE_INNER  = 3'd7;

    // one request in flight: running index / quotient, partial remainder, address
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  rest;
        logic [EXT_W-1:0]  rem;
        logic [ADDR_W-1:0] addr;
    } t_item;

endpackage

`default_nettype wire

### src/sita_div_cell.sv
// ----------------------------------------------------------------------------
// sita_div_cell
// One restoring division step: shift one index bit into the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "strided_index_to_address_defines.svh"

module sita_div_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic [sita_pkg::EXT_W-1:0] i_div,
    input  wire sita_pkg::t_item           i_item,
    output sita_pkg::t_item                o_item
);
    import sita_pkg::*;

    t_item            r_item;
    t_item            n_item;
    logic [EXT_W:0]   w_trial;
    logic             w_fit;

    always_comb begin
        w_trial = {i_item.rem, i_item.rest[IDX_W-1]};
        w_fit   = (w_trial >= {1'b0, i_div});
        n_item  = i_item;
        n_item.rest = {i_item.rest[IDX_W-2:0], w_fit};
        if (w_fit) begin
            n_item.rem = EXT_W'(w_trial - {1'b0, i_div});
        end else begin
            n_item.rem = w_trial[EXT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

    `SITA_ASSERT_NEXT(a_valid_moves, i_en && i_item.valid, r_item.valid, "valid request lost")
    `SITA_ASSERT_NEXT(a_stall_holds, !i_en, $stable(r_item), "cell changed while stalled")
    `SITA_ASSERT_NEXT(a_rem_bound, i_en && i_item.valid && (i_item.rem < i_div), r_item.rem < $past(i_div), "rem")

endmodule

`default_nettype wire

### src/sita_mac_cell.sv
// ----------------------------------------------------------------------------
// sita_mac_cell
// Scale one dimension's position by stride and item size, add to the address.
// ----------------------------------------------------------------------------
`default_nettype none

module sita_mac_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [sita_pkg::STR_W-1:0]  i_stride,
    input  wire logic [sita_pkg::SIZE_W-1:0] i_size,
    input  wire sita_pkg::t_item             i_item,
    output sita_pkg::t_item                  o_item
);
    import sita_pkg::*;

    localparam int P1_W = EXT_W + STR_W;
    localparam int P2_W = P1_W + SIZE_W;

    t_item            r_s1;
    t_item            r_s2;
    t_item            r_s3;
    t_item            n_s3;
    logic [P1_W-1:0]  r_p1;
    logic [P2_W-1:0]  r_p2;

    // add the scaled position; clear remainder for the next dimension's divide
    always_comb begin
        n_s3      = r_s2;
        n_s3.addr = r_s2.addr + ADDR_W'(r_p2);
        n_s3.rem  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= i_item;
            r_p1 <= i_item.rem * i_stride;
            r_s2 <= r_s1;
            r_p2 <= r_p1 * i_size;
            r_s3 <= n_s3;
        end
    end

    assign o_item = r_s3;

endmodule

`default_nettype wire

### src/strided_index_to_address.sv
// ----------------------------------------------------------------------------
// strided_index_to_address
// Flat row-major element index to byte address in a strided view.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream (i_s_tvalid/o_s_tready/i_s_tdata) as a
// 32-bit flat index; results leave on the master stream as a 48-bit byte
// address, one result per request, in order.
// Throughput: one request per cycle while the output is not stalled. The
// cell chain holds, per dimension, 32 restoring-divide cells (one quotient
// bit each) followed by one multiply-add cell of three register stages.
// The last cell is the output register. When the receiver stalls and that
// register is full, the whole chain holds and o_s_tready drops; it accepts
// again as soon as the result is taken.
// Reset (synchronous, active low) empties the chain and loads the register
// reset values. Configuration is written through i_cfg_* while idle.
// An extent of zero acts as one. The address wraps modulo 2^48.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_index_to_address #(
    parameter int MAX_DIMS = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [31:0]                  i_s_tdata,   // [31:0] flat_index
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [47:0]                       o_m_tdata,   // [47:0] byte_address
    input  wire logic                         i_cfg_we,
    input  wire logic [sita_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  wire logic [sita_pkg::CDATA_W-1:0] i_cfg_data
);
    import sita_pkg::*;

    localparam int DIV_STEPS = IDX_W;
    localparam int PER_DIM   = DIV_STEPS + 1;
    localparam int NBUS      = MAX_DIMS * PER_DIM + 1;

    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_size;
    logic [EXT_W-1:0]  r_ext [0:2];   // 0 inner, 1 middle, 2 outer
    logic [STR_W-1:0]  r_str [0:2];
    logic [EXT_W-1:0]  w_div [0:2];
    logic              w_en;
    t_item             w_bus [0:NBUS-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_size   <= SIZE_W'(1);
            r_ext[0] <= EXT_W'(1);
            r_ext[1] <= EXT_W'(1);
            r_ext[2] <= EXT_W'(1);
            r_str[0] <= STR_W'(1);
            r_str[1] <= '0;
            r_str[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_ADDRESS:  r_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_ITEM_SIZE:     r_size   <= i_cfg_data[SIZE_W-1:0];
                CFG_EXTENT_OUTER:  r_ext[2] <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_MIDDLE: r_ext[1] <= i_cfg_data[EXT_W-1:0];
                CFG_EXTENT_INNER:  r_ext[0] <= i_cfg_data[EXT_W-1:0];
                CFG_STRIDE_OUTER:  r_str[2] <= i_cfg_data[STR_W-1:0];
                CFG_STRIDE_MIDDLE: r_str[1] <= i_cfg_data[STR_W-1:0];
                CFG_STRIDE_INNER:  r_str[0] <= i_cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero extent divides by one
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_div[k] = (r_ext[k] == '0) ? EXT_W'(1) : r_ext[k];
        end
    end

    // hold the whole chain while the output register is full and stalled
    assign w_en       = !w_bus[NBUS-1].valid || i_m_tready;
    assign o_s_tready = w_en;

    assign w_bus[0] = '{valid: i_s_tvalid, rest: i_s_tdata, rem: '0, addr: r_base};

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
            sita_div_cell u_div (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_div  (w_div[d]),
                .i_item (w_bus[d*PER_DIM + k]),
                .o_item (w_bus[d*PER_DIM + k + 1])
            );
        end
        sita_mac_cell u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stride(r_str[d]),
            .i_size  (r_size),
            .i_item  (w_bus[d*PER_DIM + DIV_STEPS]),
            .o_item  (w_bus[(d+1)*PER_DIM])
        );
    end

    assign o_m_tvalid = w_bus[NBUS-1].valid;
    assign o_m_tdata  = w_bus[NBUS-1].addr;

endmodule

`default_nettype wire
